>>> design/cv3_pkg.sv
// ----------------------------------------------------------------------------
// cv3_pkg: shared types and constants of the 3x3 convolution filter
// Pixel, window and coefficient types, register indexes and fixed limits.
// ----------------------------------------------------------------------------
package cv3_pkg;

    localparam int PLANES      = 3;
    localparam int SAMPLE_W    = 8;
    localparam int PIXEL_W     = PLANES * SAMPLE_W;
    localparam int KERNEL_SIZE = 3;
    localparam int KERN_TAPS   = KERNEL_SIZE * KERNEL_SIZE;
    localparam int NUM_TAPS    = 6;
    localparam int HW          = 13;
    localparam int ROW_W       = 12;
    localparam int MAX_HEIGHT  = 4096;
    localparam int GAIN_W      = 18;
    localparam int PROD_W      = 17;
    localparam int SUM_W       = 20;
    localparam int SCL_W       = SUM_W + GAIN_W;
    localparam int RND_W       = SCL_W + 2;
    localparam int FRAC_W      = 17;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 48;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANES_IN_USE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP_MID  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BOTTOM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN          = 3'd5;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [PIXEL_W-1:0]  pixel_t;
    typedef pixel_t  [KERN_TAPS-1:0] window_t;
    typedef sample_t [KERN_TAPS-1:0] lane_win_t;
    typedef logic [KERN_TAPS-1:0][SAMPLE_W-1:0] coefs_t;

    typedef struct packed {
        logic fire;
        logic emit;
        logic last;
    } win_stat_t;

    typedef struct packed {
        logic s1_en;
        logic s2_en;
        logic s3_en;
    } lane_ctl_t;

endpackage

>>> design/cv3_window.sv
// ----------------------------------------------------------------------------
// cv3_window: line stores, window taps and raster counters
// Holds the two previous lines and columns and presents the 3x3 window.
// ----------------------------------------------------------------------------
module cv3_window
    import cv3_pkg::*;
#(
    parameter  int MAX_WIDTH = 1024,
    localparam int CW        = $clog2(MAX_WIDTH),
    localparam int WW        = CW + 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  pixel_t        pixel,
    input  logic          restart,
    input  logic [WW-1:0] width_eff,
    input  logic [HW-1:0] height_eff,
    output window_t       window,
    output win_stat_t     stat
);

    pixel_t top_mem [MAX_WIDTH];
    pixel_t mid_mem [MAX_WIDTH];

    logic [CW-1:0]    col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [CW-1:0]    addr_reg;
    logic             fire_reg;
    logic             emit_reg;
    logic             last_reg;
    pixel_t           px_reg;
    pixel_t           top_rd_reg;
    pixel_t           mid_rd_reg;
    pixel_t [NUM_TAPS-1:0] taps_reg;

    logic col_wrap;
    logic row_wrap;
    logic col_end;
    logic row_end;

    assign col_wrap = (WW'(col_reg) + WW'(1)) >= width_eff;
    assign row_wrap = (HW'(row_reg) + HW'(1)) >= height_eff;
    assign col_end  = (WW'(col_reg) + WW'(1)) == width_eff;
    assign row_end  = (HW'(row_reg) + HW'(1)) == height_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            fire_reg <= 1'b0;
            emit_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            fire_reg <= accept;
            if (accept)
            begin
                emit_reg <= (row_reg >= ROW_W'(2)) && (col_reg >= CW'(2));
                last_reg <= row_end && col_end;
            end
            if (restart)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (accept)
            begin
                if (col_wrap)
                begin
                    col_reg <= '0;
                    row_reg <= row_wrap ? '0 : row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
        end
    end

    // read at accept, write back and shift once the window has been used
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg     <= pixel;
            addr_reg   <= col_reg;
            top_rd_reg <= top_mem[col_reg];
            mid_rd_reg <= mid_mem[col_reg];
        end
        if (fire_reg)
        begin
            top_mem[addr_reg] <= mid_rd_reg;
            mid_mem[addr_reg] <= px_reg;
            taps_reg[0] <= taps_reg[3];
            taps_reg[1] <= taps_reg[4];
            taps_reg[2] <= taps_reg[5];
            taps_reg[3] <= top_rd_reg;
            taps_reg[4] <= mid_rd_reg;
            taps_reg[5] <= px_reg;
        end
    end

    assign window[0] = taps_reg[0];
    assign window[1] = taps_reg[3];
    assign window[2] = top_rd_reg;
    assign window[3] = taps_reg[1];
    assign window[4] = taps_reg[4];
    assign window[5] = mid_rd_reg;
    assign window[6] = taps_reg[2];
    assign window[7] = taps_reg[5];
    assign window[8] = px_reg;

    assign stat.fire = fire_reg;
    assign stat.emit = emit_reg;
    assign stat.last = last_reg;

endmodule

>>> design/cv3_lane.sv
// ----------------------------------------------------------------------------
// cv3_lane: one plane of the 3x3 convolution
// Nine products, their sum, the gain multiply, then add one half and
// truncate toward zero.
// ----------------------------------------------------------------------------
module cv3_lane
    import cv3_pkg::*;
(
    input  logic                     clk,
    input  lane_ctl_t                ctl,
    input  lane_win_t                samples,
    input  coefs_t                   coefs,
    input  logic signed [GAIN_W-1:0] gain,
    output sample_t                  result
);

    logic signed [KERN_TAPS-1:0][PROD_W-1:0] prod_reg;
    logic signed [KERN_TAPS-1:0][PROD_W-1:0] prod_next;
    logic signed [SUM_W-1:0]                 sum_reg;
    logic signed [SUM_W-1:0]                 sum_next;
    logic signed [SCL_W-1:0]                 scaled_reg;
    logic signed [SCL_W-1:0]                 scaled_next;
    logic signed [SUM_W-1:0]                 row_sum [KERNEL_SIZE];
    logic signed [RND_W-1:0]                 rnd;
    logic                                    adj;

    always_comb
    begin
        for (int i = 0; i < KERN_TAPS; i++)
        begin
            prod_next[i] = $signed({{(PROD_W-SAMPLE_W){coefs[i][SAMPLE_W-1]}}, coefs[i]})
                         * $signed({{(PROD_W-SAMPLE_W){1'b0}}, samples[i]});
        end
    end

    always_comb
    begin
        for (int r = 0; r < KERNEL_SIZE; r++)
        begin
            row_sum[r] = SUM_W'($signed(prod_reg[3*r]))
                       + SUM_W'($signed(prod_reg[3*r+1]))
                       + SUM_W'($signed(prod_reg[3*r+2]));
        end
        sum_next = row_sum[0] + row_sum[1] + row_sum[2];
    end

    assign scaled_next = SCL_W'(sum_reg) * SCL_W'(gain);

    always_ff @(posedge clk)
    begin
        if (ctl.s1_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctl.s2_en)
        begin
            sum_reg <= sum_next;
        end
        if (ctl.s3_en)
        begin
            scaled_reg <= scaled_next;
        end
    end

    // truncate toward zero: floor, then step up when negative with a fraction
    assign rnd    = $signed({scaled_reg[SCL_W-1], scaled_reg, 1'b0})
                  + $signed(RND_W'(65536));
    assign adj    = rnd[RND_W-1] & (|rnd[FRAC_W-1:0]);
    assign result = rnd[FRAC_W+SAMPLE_W-1:FRAC_W] + SAMPLE_W'(adj);

endmodule

>>> design/conv3x3_image_filter.sv
// ----------------------------------------------------------------------------
// conv3x3_image_filter: 3x3 convolution filter on a raster pixel stream
// Line stores, per-plane lanes and an output register that merges them.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, three 8-bit planes per beat. For each
// interior pixel one beat leaves carrying the three filtered planes (low
// 8 bits of the gain-scaled, rounded 3x3 sum, zero for planes at or above
// planes_in_use); border pixels give no beat and tlast marks the final
// interior pixel of a frame. One pixel is in flight at a time: a border
// pixel passes the line-store read, then write-back; an interior pixel the
// line-store read, the three registered lane stages (products, sum, gain
// multiply) and the output register; it waits while the previous output
// beat waits on m_tready. Writing image_width or image_height
// restarts the frame; the line stores keep their contents and must be
// filled by two full lines before their data reaches an output.
module conv3x3_image_filter
    import cv3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIXEL_W-1:0]    s_tdata,   // sample_0, sample_1, sample_2
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIXEL_W-1:0]    m_tdata,   // filtered_0, filtered_1, filtered_2
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;

    logic [10:0]              image_width_reg;
    logic [HW-1:0]            image_height_reg;
    logic [1:0]               planes_in_use_reg;
    logic [47:0]              coef_top_mid_reg;
    logic [23:0]              coef_bottom_reg;
    logic signed [GAIN_W-1:0] gain_reg;

    logic                 busy_reg;
    logic                 s1_v_reg;
    logic                 s2_v_reg;
    logic                 pend_reg;
    logic                 last_hold_reg;
    logic                 m_tvalid_reg;
    logic [PIXEL_W-1:0]   m_tdata_reg;
    logic                 m_tlast_reg;

    logic                 accept;
    logic                 cfg_fire;
    logic                 restart;
    logic                 load_out;
    logic [WW-1:0]        width_eff;
    logic [HW-1:0]        height_eff;
    window_t              window;
    win_stat_t            stat;
    lane_ctl_t            ctl;
    coefs_t               coefs;
    lane_win_t [PLANES-1:0] lane_samples;
    sample_t   [PLANES-1:0] lane_result;
    logic [PIXEL_W-1:0]   merged;

    assign s_tready  = !busy_reg;
    assign accept    = s_tvalid && !busy_reg;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;
    assign restart   = cfg_fire && (cfg_index == REG_IMAGE_WIDTH ||
                                    cfg_index == REG_IMAGE_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= 11'd640;
            image_height_reg  <= 13'd480;
            planes_in_use_reg <= 2'd3;
            coef_top_mid_reg  <= 48'h0001_0000_0000;
            coef_bottom_reg   <= '0;
            gain_reg          <= 18'sd65536;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[10:0];
                REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[HW-1:0];
                REG_PLANES_IN_USE: planes_in_use_reg <= cfg_data[1:0];
                REG_COEF_TOP_MID:  coef_top_mid_reg  <= cfg_data[47:0];
                REG_COEF_BOTTOM:   coef_bottom_reg   <= cfg_data[23:0];
                REG_GAIN:          gain_reg          <= $signed(cfg_data[GAIN_W-1:0]);
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        priority if (image_width_reg < 11'd3)
            width_eff = WW'(3);
        else if (32'(image_width_reg) > MAX_WIDTH)
            width_eff = WW'(MAX_WIDTH);
        else
            width_eff = WW'(image_width_reg);
    end

    always_comb
    begin
        priority if (image_height_reg < 13'd3)
            height_eff = 13'd3;
        else if (image_height_reg > 13'(MAX_HEIGHT))
            height_eff = 13'(MAX_HEIGHT);
        else
            height_eff = image_height_reg;
    end

    cv3_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .pixel      (s_tdata),
        .restart    (restart),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .window     (window),
        .stat       (stat)
    );

    assign coefs     = {coef_bottom_reg, coef_top_mid_reg};
    assign ctl.s1_en = stat.fire && stat.emit;
    assign ctl.s2_en = s1_v_reg;
    assign ctl.s3_en = s2_v_reg;

    for (genvar p = 0; p < PLANES; p++)
    begin : g_lane
        for (genvar i = 0; i < KERN_TAPS; i++)
        begin : g_tap
            assign lane_samples[p][i] = window[i][SAMPLE_W*p +: SAMPLE_W];
        end

        cv3_lane u_lane (
            .clk     (clk),
            .ctl     (ctl),
            .samples (lane_samples[p]),
            .coefs   (coefs),
            .gain    (gain_reg),
            .result  (lane_result[p])
        );

        assign merged[SAMPLE_W*p +: SAMPLE_W] =
            (2'(p) < planes_in_use_reg) ? lane_result[p] : '0;
    end

    assign load_out = pend_reg && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            priority if (accept)
                busy_reg <= 1'b1;
            else if ((stat.fire && !stat.emit) || load_out)
                busy_reg <= 1'b0;

            s1_v_reg <= ctl.s1_en;
            s2_v_reg <= s1_v_reg;

            priority if (s2_v_reg)
                pend_reg <= 1'b1;
            else if (load_out)
                pend_reg <= 1'b0;

            priority if (load_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.fire)
        begin
            last_hold_reg <= stat.last;
        end
        if (load_out)
        begin
            m_tdata_reg <= merged;
            m_tlast_reg <= last_hold_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
